@@ hw/rtl/i2cbl_pkg.sv @@
package i2cbl_pkg;

    localparam int unsigned PHASE_COUNT_WIDTH_DEF = 16;
    localparam int unsigned TICKS_WIDTH = 16;
    localparam logic [TICKS_WIDTH-1:0] PHASE_TICKS_RST = 16'd2;

    localparam int unsigned IN_TDATA_WIDTH = 16;
    localparam int unsigned OUT_TDATA_WIDTH = 16;

    typedef enum logic [2:0] {
        CMD_IDLE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    // Phases within a bit (or within a start or stop condition).
    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_MID   = 2'd1;
    localparam logic [1:0] PH_LAST  = 2'd2;

    // Bit index of the acknowledge slot after the eight data bits.
    localparam logic [3:0] ACK_BIT = 4'd8;

    // Packed so that the first field sits in the highest bits.
    typedef struct packed {
        logic       sda_in;
        logic       master_ack;
        logic [7:0] tx_byte;
        logic [2:0] mode;
    } in_item_t;

    typedef struct packed {
        logic       cmd_done;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_level;
        logic       scl_drive;
        logic       scl_level;
    } out_item_t;

    typedef struct packed {
        logic sda_drive;
        logic sda_level;
        logic scl_drive;
        logic scl_level;
    } pins_t;

endpackage

@@ hw/rtl/i2cbl_seq.sv @@
module i2cbl_seq #(
    parameter int unsigned PHASE_COUNT_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  step_en,
    input  logic [i2cbl_pkg::TICKS_WIDTH-1:0]     phase_ticks,
    input  i2cbl_pkg::in_item_t                   item,
    output i2cbl_pkg::out_item_t                  result
);
    import i2cbl_pkg::*;

    localparam int unsigned CW = PHASE_COUNT_WIDTH;
    localparam logic [32:0] CNT_MAX = (33'd1 << CW) - 33'd1;

    logic [CW-1:0] cnt_reg, cnt_next;
    cmd_t          cmd_reg, cmd_next;
    logic [3:0]    bit_reg, bit_next;
    logic [1:0]    ph_reg, ph_next;
    logic [7:0]    shift_reg, shift_next;
    logic          ack_reg, ack_next;
    pins_t         pins_reg, pins_next;
    logic [7:0]    rx_hold_reg, rx_hold_next;

    logic [TICKS_WIDTH-1:0] load16;
    logic [CW-1:0]          cnt_load;
    logic                   fin;
    logic                   rx_valid;
    logic                   done;

    function automatic pins_t drive_phase(cmd_t c, logic [1:0] ph, logic [3:0] bi,
                                          logic [7:0] sh, logic ack);
        pins_t p;
        p.scl_drive = 1'b1;
        p.sda_drive = 1'b1;
        unique case (c)
            CMD_START:
            begin
                p.sda_level = (ph == PH_FIRST);
                p.scl_level = (ph != PH_LAST);
            end
            CMD_STOP:
            begin
                p.sda_level = (ph != PH_FIRST);
                p.scl_level = 1'b1;
            end
            default:
            begin
                p.scl_level = (ph == PH_MID);
                if (c == CMD_WRITE && bi < ACK_BIT)
                begin
                    p.sda_level = sh[7];
                end
                else if (c == CMD_READ && bi == ACK_BIT)
                begin
                    p.sda_level = ~ack;
                end
                else
                begin
                    p.sda_level = 1'b1;
                    p.sda_drive = 1'b0;
                end
            end
        endcase
        return p;
    endfunction

    // A zero setting counts as one tick; large settings saturate the counter.
    always_comb
    begin
        load16 = (phase_ticks == '0) ? '0 : phase_ticks - 1'b1;
        if ({17'd0, load16} > CNT_MAX)
            cnt_load = CNT_MAX[CW-1:0];
        else
            cnt_load = CW'(load16);
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        cmd_next     = cmd_reg;
        bit_next     = bit_reg;
        ph_next      = ph_reg;
        shift_next   = shift_reg;
        ack_next     = ack_reg;
        pins_next    = pins_reg;
        rx_hold_next = rx_hold_reg;
        fin          = 1'b0;
        rx_valid     = 1'b0;
        done         = 1'b0;

        if (cmd_reg == CMD_IDLE)
        begin
            case (item.mode) inside
                CMD_START, CMD_STOP, CMD_WRITE, CMD_READ:
                begin
                    cmd_next = cmd_t'(item.mode);
                    bit_next = '0;
                    ph_next  = PH_FIRST;
                    if (item.mode == CMD_WRITE)
                        shift_next = item.tx_byte;
                    else if (item.mode == CMD_READ)
                        shift_next = '0;
                    ack_next  = item.master_ack;
                    cnt_next  = cnt_load;
                    pins_next = drive_phase(cmd_t'(item.mode), PH_FIRST, 4'd0,
                                            shift_next, item.master_ack);
                end
                default:
                begin
                end
            endcase
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
        else
        begin
            case (cmd_reg)
                CMD_START:
                begin
                    fin     = (ph_reg >= PH_LAST);
                    ph_next = ph_reg + 1'b1;
                end
                CMD_STOP:
                begin
                    fin     = (ph_reg >= PH_MID);
                    ph_next = ph_reg + 1'b1;
                end
                default:
                begin
                    // Read data is sampled as the clock-high phase ends.
                    if (ph_reg == PH_MID && cmd_reg == CMD_READ && bit_reg < ACK_BIT)
                        shift_next = {shift_reg[6:0], item.sda_in};
                    if (ph_reg < PH_LAST)
                    begin
                        ph_next = ph_reg + 1'b1;
                    end
                    else if (bit_reg >= ACK_BIT)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        if (cmd_reg == CMD_WRITE)
                            shift_next = {shift_reg[6:0], 1'b0};
                        bit_next = bit_reg + 1'b1;
                        ph_next  = PH_FIRST;
                    end
                end
            endcase

            if (fin)
            begin
                done = 1'b1;
                pins_next.scl_drive = 1'b1;
                pins_next.sda_drive = 1'b1;
                if (cmd_reg == CMD_STOP)
                begin
                    pins_next = '{sda_drive: 1'b0, sda_level: 1'b1,
                                  scl_drive: 1'b0, scl_level: 1'b1};
                end
                else if (cmd_reg == CMD_START)
                begin
                    pins_next.scl_level = 1'b0;
                    pins_next.sda_level = 1'b0;
                end
                else
                begin
                    pins_next.scl_level = 1'b0;
                    pins_next.sda_level = 1'b1;
                    if (cmd_reg == CMD_READ)
                    begin
                        rx_hold_next = shift_next;
                        rx_valid     = 1'b1;
                    end
                end
                cmd_next = CMD_IDLE;
                bit_next = '0;
                ph_next  = PH_FIRST;
                cnt_next = '0;
            end
            else
            begin
                cnt_next  = cnt_load;
                pins_next = drive_phase(cmd_reg, ph_next, bit_next, shift_next, ack_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            cmd_reg     <= CMD_IDLE;
            bit_reg     <= '0;
            ph_reg      <= PH_FIRST;
            shift_reg   <= '0;
            ack_reg     <= 1'b0;
            pins_reg    <= '{sda_drive: 1'b0, sda_level: 1'b1,
                             scl_drive: 1'b0, scl_level: 1'b1};
            rx_hold_reg <= '0;
        end
        else if (step_en)
        begin
            cnt_reg     <= cnt_next;
            cmd_reg     <= cmd_next;
            bit_reg     <= bit_next;
            ph_reg      <= ph_next;
            shift_reg   <= shift_next;
            ack_reg     <= ack_next;
            pins_reg    <= pins_next;
            rx_hold_reg <= rx_hold_next;
        end
    end

    always_comb
    begin
        result.scl_level = pins_next.scl_level;
        result.scl_drive = pins_next.scl_drive;
        result.sda_level = pins_next.sda_level;
        result.sda_drive = pins_next.sda_drive;
        result.busy_res  = (cmd_next != CMD_IDLE);
        result.rx_byte   = rx_hold_next;
        result.rx_valid  = rx_valid;
        result.cmd_done  = done;
    end

endmodule

@@ hw/rtl/i2c_bit_level_master_top.sv @@
// Bit-level I2C master sequencer.
//
// Every input word on the s_axis channel is one tick of the bus sequencer:
// it carries an optional command (start, stop, write byte, read byte) and
// the sampled SDA level. For every input word exactly one result word
// leaves on the m_axis channel, giving the SCL and SDA levels and enables
// after that tick, the busy flag, the last read byte and the done flags.
// Each bus phase lasts phase_ticks ticks, set through cfg_wr_en and
// cfg_wr_data; the user must write it only while no command is running,
// as the block itself does not enforce this.
//
// An input word passes through the input register and then the sequencer,
// which updates its state and loads the result register together.
// Throughput is one word per cycle while the receiver does not stall.
// Reset clears the sequencer to idle with both pins released and high and
// sets phase_ticks to 2. When the receiver holds m_axis_tready low, the
// result register holds its word, an empty input register takes one more
// input word, and then s_axis_tready falls until the result is taken.
module i2c_bit_level_master_top #(
    parameter int unsigned PHASE_COUNT_WIDTH = i2cbl_pkg::PHASE_COUNT_WIDTH_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_wr_en,
    input  logic [i2cbl_pkg::TICKS_WIDTH-1:0]         cfg_wr_data,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // mode[2:0], tx_byte[10:3], master_ack[11], sda_in[12], zero[15:13]
    input  logic [i2cbl_pkg::IN_TDATA_WIDTH-1:0]      s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // scl_level[0], scl_drive[1], sda_level[2], sda_drive[3], busy_res[4],
    // rx_byte[12:5], rx_valid[13], cmd_done[14], zero[15]
    output logic [i2cbl_pkg::OUT_TDATA_WIDTH-1:0]     m_axis_tdata
);
    import i2cbl_pkg::*;

    logic [TICKS_WIDTH-1:0] phase_ticks_reg;
    logic                   in_valid_reg;
    in_item_t               in_item_reg;
    logic                   out_valid_reg;
    out_item_t              out_item_reg;
    out_item_t              result;
    logic                   advance;
    logic                   step_en;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step_en       = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            phase_ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_item_reg <= s_axis_tdata[$bits(in_item_t)-1:0];
        if (step_en)
            out_item_reg <= result;
    end

    i2cbl_seq #(
        .PHASE_COUNT_WIDTH (PHASE_COUNT_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .phase_ticks (phase_ticks_reg),
        .item        (in_item_reg),
        .result      (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_WIDTH - $bits(out_item_t)){1'b0}}, out_item_reg};

endmodule

@@ hw/rtl/i2cbl_checker.sv @@
module i2cbl_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [i2cbl_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata
);
    import i2cbl_pkg::*;

    // A stalled result word stays unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // A finishing command is never reported as still busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[14] |-> !m_axis_tdata[4])
        else $error("busy flag set on the completing word");

    // A completed read is always also a completed command.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[13] |-> m_axis_tdata[14])
        else $error("read completion without command completion");

    // A released SCL only occurs on an idle bus, after reset or a stop, where both lines are high and free.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[1] |->
            m_axis_tdata[0] && m_axis_tdata[2] && !m_axis_tdata[3] && !m_axis_tdata[4])
        else $error("SCL released outside the idle bus state");

endmodule

bind i2c_bit_level_master_top i2cbl_checker u_i2cbl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ tb/sv/tb.sv @@
module tb;
    import i2cbl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_LIMIT = 40;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_kind_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [TICKS_WIDTH-1:0] cfg_wr_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_WIDTH-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;

    i2c_bit_level_master_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Sequencer state as the bus controller should hold it.
    logic [TICKS_WIDTH-1:0]           seq_ticks = PHASE_TICKS_RST;
    logic [PHASE_COUNT_WIDTH_DEF-1:0] seq_count = '0;
    cmd_t                             seq_cmd = CMD_IDLE;
    logic [3:0]                       seq_bit = '0;
    logic [1:0]                       seq_phase = PH_FIRST;
    logic [7:0]                       seq_shift = '0;
    logic                             seq_ack = 1'b0;
    pins_t                            seq_pins = '{sda_drive: 1'b0, sda_level: 1'b1,
                                                   scl_drive: 1'b0, scl_level: 1'b1};
    logic [7:0]                       seq_rx = '0;

    in_item_t  tick_queue[$];
    out_item_t pin_expect[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic in_fire = 1'b0;
    int quiet_cycles = 0;
    int n_pushed = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_cmds = 0;
    int n_reads = 0;

    function automatic logic [PHASE_COUNT_WIDTH_DEF-1:0] phase_reload();
        logic [TICKS_WIDTH-1:0] t;
        t = (seq_ticks == '0) ? TICKS_WIDTH'(1) : seq_ticks;
        return PHASE_COUNT_WIDTH_DEF'(t - TICKS_WIDTH'(1));
    endfunction

    function automatic void drive_pins();
        seq_pins.scl_drive = 1'b1;
        seq_pins.sda_drive = 1'b1;
        case (seq_cmd)
            CMD_START:
            begin
                seq_pins.sda_level = (seq_phase == PH_FIRST);
                seq_pins.scl_level = (seq_phase != PH_LAST);
            end
            CMD_STOP:
            begin
                seq_pins.sda_level = (seq_phase != PH_FIRST);
                seq_pins.scl_level = 1'b1;
            end
            default:
            begin
                seq_pins.scl_level = (seq_phase == PH_MID);
                if (seq_cmd == CMD_WRITE && seq_bit < ACK_BIT)
                    seq_pins.sda_level = seq_shift[7];
                else if (seq_cmd == CMD_READ && seq_bit == ACK_BIT)
                    seq_pins.sda_level = !seq_ack;
                else
                begin
                    seq_pins.sda_level = 1'b1;
                    seq_pins.sda_drive = 1'b0;
                end
            end
        endcase
    endfunction

    // Steps to the next phase; returns 1 once the command has run its course.
    function automatic logic advance_phase(input logic sda);
        logic fin;
        if (seq_cmd == CMD_START)
        begin
            fin = (seq_phase >= PH_LAST);
            seq_phase++;
            return fin;
        end
        if (seq_cmd == CMD_STOP)
        begin
            fin = (seq_phase >= PH_MID);
            seq_phase++;
            return fin;
        end
        if (seq_phase == PH_MID && seq_cmd == CMD_READ && seq_bit < ACK_BIT)
            seq_shift = {seq_shift[6:0], sda};
        if (seq_phase < PH_LAST)
        begin
            seq_phase++;
            return 1'b0;
        end
        if (seq_bit >= ACK_BIT)
            return 1'b1;
        if (seq_cmd == CMD_WRITE)
            seq_shift = {seq_shift[6:0], 1'b0};
        seq_bit++;
        seq_phase = PH_FIRST;
        return 1'b0;
    endfunction

    function automatic out_item_t bus_tick(input in_item_t it);
        out_item_t r;
        logic done;
        logic valid;
        done = 1'b0;
        valid = 1'b0;
        if (seq_cmd == CMD_IDLE)
        begin
            if (it.mode >= CMD_START && it.mode <= CMD_READ)
            begin
                seq_cmd = cmd_t'(it.mode);
                seq_bit = '0;
                seq_phase = PH_FIRST;
                if (seq_cmd == CMD_WRITE)
                    seq_shift = it.tx_byte;
                else if (seq_cmd == CMD_READ)
                    seq_shift = '0;
                seq_ack = it.master_ack;
                seq_count = phase_reload();
                drive_pins();
            end
        end
        else if (seq_count != '0)
            seq_count--;
        else if (advance_phase(it.sda_in))
        begin
            done = 1'b1;
            if (seq_cmd == CMD_STOP)
                seq_pins = '{sda_drive: 1'b0, sda_level: 1'b1, scl_drive: 1'b0, scl_level: 1'b1};
            else if (seq_cmd == CMD_START)
                seq_pins = '{sda_drive: 1'b1, sda_level: 1'b0, scl_drive: 1'b1, scl_level: 1'b0};
            else
            begin
                seq_pins = '{sda_drive: 1'b1, sda_level: 1'b1, scl_drive: 1'b1, scl_level: 1'b0};
                if (seq_cmd == CMD_READ)
                begin
                    seq_rx = seq_shift;
                    valid = 1'b1;
                end
            end
            seq_cmd = CMD_IDLE;
            seq_bit = '0;
            seq_phase = PH_FIRST;
            seq_count = '0;
        end
        else
        begin
            seq_count = phase_reload();
            drive_pins();
        end
        r.scl_level = seq_pins.scl_level;
        r.scl_drive = seq_pins.scl_drive;
        r.sda_level = seq_pins.sda_level;
        r.sda_drive = seq_pins.sda_drive;
        r.busy_res = (seq_cmd != CMD_IDLE);
        r.rx_byte = seq_rx;
        r.rx_valid = valid;
        r.cmd_done = done;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        n_errors++;
        if (n_errors <= PRINT_LIMIT)
            $display("MISMATCH word %0d: %s got %0h expected %0h", n_checked, what, got, want);
    endtask

    task automatic check_word(input out_item_t got, input out_item_t want);
        if (got.scl_level !== want.scl_level)
            report_mismatch("scl_level", got.scl_level, want.scl_level);
        if (got.scl_drive !== want.scl_drive)
            report_mismatch("scl_drive", got.scl_drive, want.scl_drive);
        if (got.sda_level !== want.sda_level)
            report_mismatch("sda_level", got.sda_level, want.sda_level);
        if (got.sda_drive !== want.sda_drive)
            report_mismatch("sda_drive", got.sda_drive, want.sda_drive);
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
        if (got.rx_byte !== want.rx_byte)
            report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
        if (got.rx_valid !== want.rx_valid)
            report_mismatch("rx_valid", got.rx_valid, want.rx_valid);
        if (got.cmd_done !== want.cmd_done)
            report_mismatch("cmd_done", got.cmd_done, want.cmd_done);
    endtask

    // Driver: a new word is offered only once the current one has gone.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_fire)
            begin
                if (tick_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    s_axis_tdata <= {{(IN_TDATA_WIDTH - $bits(in_item_t)){1'b0}},
                                     tick_queue.pop_front()};
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts on every accepted input word and checks every output word.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_fire <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                pin_expect.push_back(bus_tick(in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0])));
                if (pin_expect[$].rx_valid)
                    n_reads++;
                n_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pin_expect.size() == 0)
                    report_mismatch("unexpected word", m_axis_tdata, 0);
                else
                    check_word(out_item_t'(m_axis_tdata[$bits(out_item_t)-1:0]),
                               pin_expect.pop_front());
                n_checked++;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", quiet_cycles);
                $display("i2c_bit_level_master_top verification failed");
                $finish;
            end
        end
    end

    function automatic int cmd_span(input cmd_t c);
        int p;
        p = (seq_ticks == '0) ? 1 : int'(seq_ticks);
        case (c)
            CMD_START: return 3 * p;
            CMD_STOP:  return 2 * p;
            default:   return 27 * p;
        endcase
    endfunction

    function automatic logic pick_sda(input int sda_fix);
        return (sda_fix < 0) ? 1'($urandom) : 1'(sda_fix);
    endfunction

    task automatic push_tick(input logic [2:0] mode, input logic [7:0] tx, input logic ack,
                             input logic sda);
        in_item_t it;
        it.mode = mode;
        it.tx_byte = tx;
        it.master_ack = ack;
        it.sda_in = sda;
        tick_queue.push_back(it);
        n_pushed++;
    endtask

    // Ticks while idle: either no command or one of the unused codes.
    task automatic idle_gap(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(1) == 0)
                push_tick(CMD_IDLE, 8'($urandom), 1'($urandom), 1'($urandom));
            else
                push_tick(3'(int'(CMD_READ) + 1 + $urandom_range(2)), 8'($urandom),
                          1'($urandom), 1'($urandom));
        end
    endtask

    // One command and exactly the ticks it keeps the sequencer busy; noise_pct of
    // those ticks carry a random code, which the block must ignore.
    task automatic issue(input cmd_t c, input logic [7:0] tx, input logic ack,
                         input int sda_fix, input int noise_pct);
        int span;
        span = cmd_span(c);
        push_tick(c, tx, ack, pick_sda(sda_fix));
        for (int i = 0; i < span; i++)
        begin
            if ($urandom_range(99) < noise_pct)
                push_tick(3'($urandom), 8'($urandom), 1'($urandom), pick_sda(sda_fix));
            else
                push_tick(CMD_IDLE, 8'($urandom), 1'($urandom), pick_sda(sda_fix));
        end
        n_cmds++;
    endtask

    task automatic random_transfer();
        int nbytes;
        nbytes = $urandom_range(1, 3);
        if ($urandom_range(9) != 0)
            issue(CMD_START, 8'($urandom), 1'($urandom), -1, 3);
        for (int i = 0; i < nbytes; i++)
        begin
            if ($urandom_range(1) == 0)
                issue(CMD_WRITE, 8'($urandom), 1'($urandom), -1, 3);
            else
                issue(CMD_READ, 8'($urandom), 1'($urandom), -1, 3);
            idle_gap($urandom_range(0, 2));
        end
        if ($urandom_range(9) != 0)
            issue(CMD_STOP, 8'($urandom), 1'($urandom), -1, 3);
        // A stray command now and then knocks the sequence out of step.
        if ($urandom_range(19) == 0)
            push_tick(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
        idle_gap($urandom_range(0, 3));
    endtask

    // Waits until every word is through and the sequencer is idle again.
    task automatic settle();
        do
        begin
            @(negedge clk);
            while (n_accepted != n_pushed || pin_expect.size() != 0)
                @(negedge clk);
            if (seq_cmd != CMD_IDLE)
                idle_gap(16);
        end
        while (seq_cmd != CMD_IDLE);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_ticks(input logic [TICKS_WIDTH-1:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        seq_ticks = v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input idle_kind_t k);
        case (k)
            IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 67; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 67; end
            default:   begin send_idle_pct = 28; recv_stall_pct = 28; end
        endcase
    endtask

    task automatic random_phase(input logic [TICKS_WIDTH-1:0] ticks, input idle_kind_t k,
                                input int budget);
        int first;
        set_ticks(ticks);
        set_idling(k);
        first = n_pushed;
        while (n_pushed - first < budget)
            random_transfer();
        settle();
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset phase length.
        idle_gap(1);
        for (int m = int'(CMD_READ) + 1; m < 8; m++)
            push_tick(3'(m), 8'hFF, 1'b1, 1'b1);
        issue(CMD_START, 8'h00, 1'b0, -1, 0);
        issue(CMD_WRITE, 8'h00, 1'b0, -1, 0);
        issue(CMD_WRITE, 8'hFF, 1'b1, -1, 0);
        issue(CMD_READ, 8'hFF, 1'b1, 1, 0);
        issue(CMD_READ, 8'h00, 1'b0, 0, 0);
        // Every busy tick of this write carries a random code.
        issue(CMD_WRITE, 8'hA5, 1'b0, -1, 100);
        issue(CMD_READ, 8'($urandom), 1'b1, -1, 0);
        issue(CMD_START, 8'h00, 1'b0, -1, 0);
        issue(CMD_STOP, 8'hFF, 1'b1, -1, 0);
        issue(CMD_STOP, 8'h00, 1'b0, -1, 0);
        idle_gap(2);
        issue(CMD_READ, 8'($urandom), 1'b0, -1, 0);
        issue(CMD_STOP, 8'h00, 1'b0, -1, 0);
        settle();

        // A zero phase length behaves as one tick.
        set_ticks(16'd0);
        issue(CMD_START, 8'h00, 1'b0, -1, 0);
        issue(CMD_WRITE, 8'($urandom), 1'b0, -1, 0);
        issue(CMD_READ, 8'($urandom), 1'b0, -1, 0);
        issue(CMD_STOP, 8'h00, 1'b0, -1, 0);
        settle();

        for (int i = 0; i < 4; i++)
            random_phase(16'd1, idle_kind_t'(i), 30);

        repeat (8) @(negedge clk);
        if (pin_expect.size() != 0)
            report_mismatch("words never delivered", pin_expect.size(), 0);
        $display("Ran %0d bus commands over %0d ticks, %0d bytes read back,", n_cmds,
                 n_accepted, n_reads);
        $display("phase lengths 0, 1 and 2 under four idling patterns; %0d words checked.",
                 n_checked);
        if (n_errors == 0)
            $display("i2c_bit_level_master_top verification clean");
        else
            $display("i2c_bit_level_master_top verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/i2cbl_pkg.sv
hw/rtl/i2cbl_seq.sv
hw/rtl/i2c_bit_level_master_top.sv
hw/rtl/i2cbl_checker.sv
tb/sv/tb.sv
